>>> rtl/button_short_long_press_detector_defines.svh
// ----------------------------------------------------------------------------
// button_short_long_press_detector_defines.svh
// Assertion macros used by the press detector top level.
// ----------------------------------------------------------------------------
`ifndef BUTTON_SHORT_LONG_PRESS_DETECTOR_DEFINES_SVH
`define BUTTON_SHORT_LONG_PRESS_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BSPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BSPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bspd_pkg.sv
// ----------------------------------------------------------------------------
// bspd_pkg
// Shared types and constants of the short/long press detector.
// ----------------------------------------------------------------------------
package bspd_pkg;

  // Number of button lanes (one port per button on the top level)
  localparam int NUM_BUTTONS = 4;

  localparam int TIME_W = 32;
  localparam int THR_W  = 16;

  localparam logic [THR_W-1:0] SHORT_THR_RST = THR_W'(50);
  localparam logic [THR_W-1:0] LONG_THR_RST  = THR_W'(1000);

  // Per-button phase
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_DEB_PRESS   = 3'd1,
    PH_PRESSED     = 3'd2,
    PH_LONG_HELD   = 3'd3,
    PH_DEB_RELEASE = 3'd4
  } phase_t;

  // Event codes reported per button
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } event_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_SHORT_THR = 1'b0,
    REG_LONG_THR  = 1'b1
  } cfg_reg_t;

  // Thresholds handed to every lane
  typedef struct packed {
    logic [THR_W-1:0] short_ms;
    logic [THR_W-1:0] long_ms;
  } thr_cfg_t;

endpackage

>>> rtl/button_short_long_press_detector.sv
// ----------------------------------------------------------------------------
// button_short_long_press_detector
// Four-button debounce with short and long press events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one pressed bit per button and
//   the free-running millisecond time in_now_ms. Each transaction advances
//   all four button machines together, one lane per button.
//   Output channel (out_valid/out_ready) returns one event code per button
//   for every input transaction: none, short press or long press.
//   The result is registered at the accepting edge.
//   Throughput is one transaction per cycle unless the output stalls; each lane
//   does one 32-bit elapsed-time subtract and two threshold compares per transaction.
//   When the receiver stalls, the result stays in the output register and
//   in_ready drops until it is taken; in_ready follows out_ready then.
//   Config channel (cfg_valid/cfg_ready, always ready) writes index 0, the
//   debounce threshold, or index 1, the long-hold threshold, in ms.
//   Reset (rst_n low, synchronous) sets thresholds to 50 and 1000 ms, all
//   buttons idle and the output register empty.
// ----------------------------------------------------------------------------
module button_short_long_press_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_pressed_0,
  input  logic                          in_pressed_1,
  input  logic                          in_pressed_2,
  input  logic                          in_pressed_3,
  input  logic [bspd_pkg::TIME_W-1:0]   in_now_ms,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_event_0,
  output logic [1:0]                    out_event_1,
  output logic [1:0]                    out_event_2,
  output logic [1:0]                    out_event_3,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [0:0]                    cfg_index,
  input  logic [bspd_pkg::THR_W-1:0]    cfg_wdata
);
  import bspd_pkg::*;

`include "button_short_long_press_detector_defines.svh"

  logic                       in_fire;
  logic                       can_load;
  logic [NUM_BUTTONS-1:0]     down;
  thr_cfg_t                   thr_r;
  event_t [NUM_BUTTONS-1:0]   lane_ev;
  event_t [NUM_BUTTONS-1:0]   out_ev;

  assign cfg_ready = 1'b1;
  assign in_ready  = can_load;
  assign in_fire   = in_valid && can_load;
  assign down      = {in_pressed_3, in_pressed_2, in_pressed_1, in_pressed_0};

  // Threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.short_ms <= SHORT_THR_RST;
      thr_r.long_ms  <= LONG_THR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SHORT_THR: thr_r.short_ms <= cfg_wdata;
        REG_LONG_THR:  thr_r.long_ms  <= cfg_wdata;
      endcase
    end
  end

  // One machine per button
  for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
    bspd_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .step   (in_fire),
      .down   (down[g]),
      .now_ms (in_now_ms),
      .thr    (thr_r),
      .ev     (lane_ev[g])
    );
  end

  // Output register
  bspd_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_fire),
    .lane_ev   (lane_ev),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_ev    (out_ev),
    .can_load  (can_load)
  );

  assign out_event_0 = out_ev[0];
  assign out_event_1 = out_ev[1];
  assign out_event_2 = out_ev[2];
  assign out_event_3 = out_ev[3];

  // Checks
  `BSPD_ASSERT_NOW(a_stall_blocks_input, out_valid && !out_ready, !in_ready, "input taken while output stalled")
  `BSPD_ASSERT_NEXT(a_accept_gives_result, in_valid && in_ready, out_valid, "accepted transaction produced no result")
  `BSPD_ASSERT_NOW(a_no_bad_event, out_valid, (out_event_0 != 2'b11) && (out_event_1 != 2'b11) && (out_event_2 != 2'b11) && (out_event_3 != 2'b11), "undefined event code on output")

endmodule

>>> rtl/bspd_lane.sv
// ----------------------------------------------------------------------------
// bspd_lane
// One button: debounce/short/long phase machine with its own time mark.
// ----------------------------------------------------------------------------
module bspd_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic                          down,
  input  logic [bspd_pkg::TIME_W-1:0]   now_ms,
  input  bspd_pkg::thr_cfg_t            thr,
  output bspd_pkg::event_t              ev
);
  import bspd_pkg::*;

  phase_t              phase_r, phase_nxt;
  logic [TIME_W-1:0]   mark_r, mark_nxt;
  logic                long_fired_r, long_fired_nxt;
  logic [TIME_W-1:0]   elapsed;
  logic                short_met;
  logic                long_met;

  // Wrapping elapsed time against the mark
  assign elapsed   = now_ms - mark_r;
  assign short_met = (elapsed >= {{(TIME_W-THR_W){1'b0}}, thr.short_ms});
  assign long_met  = (elapsed >= {{(TIME_W-THR_W){1'b0}}, thr.long_ms});

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_DEB_PRESS: begin
        if (!down) phase_nxt = PH_IDLE;
        else if (short_met) phase_nxt = PH_PRESSED;
      end
      PH_PRESSED: begin
        if (!down) phase_nxt = PH_DEB_RELEASE;
        else if (long_met) phase_nxt = PH_LONG_HELD;
      end
      PH_LONG_HELD: begin
        if (!down) phase_nxt = PH_DEB_RELEASE;
      end
      PH_DEB_RELEASE: begin
        if (down) phase_nxt = PH_PRESSED;
        else if (short_met) phase_nxt = PH_IDLE;
      end
      default: begin
        // idle, and unused codes behave as idle
        phase_nxt = down ? PH_DEB_PRESS : PH_IDLE;
      end
    endcase
  end

  // Event, mark and long flag
  always_comb begin
    ev             = EV_NONE;
    mark_nxt       = mark_r;
    long_fired_nxt = long_fired_r;
    unique case (phase_r)
      PH_DEB_PRESS: begin
        if (down && short_met) mark_nxt = now_ms;
      end
      PH_PRESSED: begin
        if (!down) begin
          mark_nxt = now_ms;
        end else if (long_met) begin
          ev             = EV_LONG;
          long_fired_nxt = 1'b1;
        end
      end
      PH_LONG_HELD: begin
        if (!down) mark_nxt = now_ms;
      end
      PH_DEB_RELEASE: begin
        // a bounce keeps the release mark
        if (!down && short_met) begin
          if (!long_fired_r) ev = EV_SHORT;
          long_fired_nxt = 1'b0;
        end
      end
      default: begin
        if (down) begin
          mark_nxt       = now_ms;
          long_fired_nxt = 1'b0;
        end
      end
    endcase
  end

  // State update on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      mark_r       <= '0;
      long_fired_r <= 1'b0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      mark_r       <= mark_nxt;
      long_fired_r <= long_fired_nxt;
    end
  end

endmodule

>>> rtl/bspd_merge.sv
// ----------------------------------------------------------------------------
// bspd_merge
// Collects the lane events of one transaction into the output register.
// ----------------------------------------------------------------------------
module bspd_merge (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  bspd_pkg::event_t [bspd_pkg::NUM_BUTTONS-1:0] lane_ev,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output bspd_pkg::event_t [bspd_pkg::NUM_BUTTONS-1:0] out_ev,
  output logic                                   can_load
);
  import bspd_pkg::*;

  logic                        out_valid_r, out_valid_nxt;
  event_t [NUM_BUTTONS-1:0]    ev_r;

  // Room when empty or the held result leaves this cycle
  assign can_load = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // Valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event payload
  always_ff @(posedge clk) begin
    if (load) begin
      ev_r <= lane_ev;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ev    = ev_r;

endmodule
